### sv/uart_command_frame_decoder_core_macros.svh
// Assertion helpers used by the checker module of the frame decoder.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef UART_COMMAND_FRAME_DECODER_CORE_MACROS_SVH
`define UART_COMMAND_FRAME_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ucfd_pkg.sv
package ucfd_pkg;

  // Field types of the byte and result channels.
  typedef logic [7:0] byte_t;
  typedef logic [2:0] cmd_t;
  typedef logic [6:0] period_t;
  typedef logic [1:0] phase_t;

  // Framing characters.
  localparam byte_t BYTE_START = 8'h26;
  localparam byte_t BYTE_END   = 8'h2A;
  localparam byte_t BYTE_T     = 8'h54;
  localparam byte_t BYTE_USCORE = 8'h5F;
  localparam byte_t BYTE_ZERO  = 8'h30;
  localparam byte_t BYTE_NINE  = 8'h39;

  // Mode words, first character in the top byte.
  localparam logic [31:0] WORD_NORM = 32'h6E6F726D;
  localparam logic [31:0] WORD_HUMD = 32'h68756D64;
  localparam logic [31:0] WORD_TEMP = 32'h74656D70;

  // Command codes.
  localparam cmd_t CMD_NORMAL  = 3'd0;
  localparam cmd_t CMD_HUMID   = 3'd1;
  localparam cmd_t CMD_TEMP    = 3'd2;
  localparam cmd_t CMD_PERIOD  = 3'd3;
  localparam cmd_t CMD_UNKNOWN = 3'd4;

  // Frame phase codes; the unused code behaves as idle.
  localparam phase_t PHASE_IDLE    = 2'd0;
  localparam phase_t PHASE_COLLECT = 2'd1;
  localparam phase_t PHASE_DISCARD = 2'd2;

  // Largest period value that two digits can give.
  localparam period_t PERIOD_MAX = 7'd99;

endpackage

### sv/uart_command_frame_decoder_core.sv
// A result for the closing '*' is registered in the result register, or in the skid register while out_ is stalled.
// Throughput: one byte per cycle while in_stall is low; the frame buffer and decode sit between the byte
// input and a result register backed by a one-entry skid register.
// Reset: rst_n is synchronous and active low; it returns the decoder to idle, clears the
// byte count and empties the result and skid registers. Buffer contents are not reset.
module uart_command_frame_decoder_core
  import ucfd_pkg::*;
#(
  parameter int FRAME_LEN = 6
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  byte_t   in_rx_byte,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    out_command,
  output period_t out_period_value
);

  localparam int SLOTS = FRAME_LEN - 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [CNT_W-1:0] SLOT_CNT  = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] MODE_CNT  = CNT_W'(4);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  byte_t            frame_r [SLOTS];

  logic    accept;
  logic    is_start;
  logic    is_end;
  logic    wr_en;
  logic    res_valid;
  cmd_t    res_command;
  period_t res_period;

  byte_t       eff [4];
  logic [31:0] word;
  logic        dig2, dig3;
  period_t     d2, d3;

  logic    out_valid_r;
  cmd_t    out_command_r;
  period_t out_period_r;
  logic    skid_valid_r;
  cmd_t    skid_command_r;
  period_t skid_period_r;
  logic    out_held;

  assign accept   = in_valid & ~in_stall;
  assign is_start = (in_rx_byte == BYTE_START);
  assign is_end   = (in_rx_byte == BYTE_END);

  // Frame tracking: start, store, close or overflow on each accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    res_valid = 1'b0;
    if (accept) begin
      if (is_start) begin
        phase_nxt = PHASE_COLLECT;
        count_nxt = '0;
      end else if (phase_r == PHASE_COLLECT) begin
        if (count_r >= SLOT_CNT) begin
          phase_nxt = PHASE_DISCARD;
          count_nxt = '0;
        end else begin
          wr_en = 1'b1;
          if (is_end) begin
            res_valid = 1'b1;
            phase_nxt = PHASE_IDLE;
            count_nxt = '0;
          end else if (count_r == LAST_SLOT) begin
            phase_nxt = PHASE_DISCARD;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Frame buffer, written at the current byte position.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_r[count_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  // The closing byte is not yet in the buffer, so it stands in at its own position.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      eff[j] = (count_r == CNT_W'(j)) ? in_rx_byte : frame_r[j];
    end
  end

  assign word = {eff[0], eff[1], eff[2], eff[3]};
  assign dig2 = (eff[2] >= BYTE_ZERO) && (eff[2] <= BYTE_NINE);
  assign dig3 = (eff[3] >= BYTE_ZERO) && (eff[3] <= BYTE_NINE);
  assign d2   = {3'b000, eff[2][3:0]};
  assign d3   = {3'b000, eff[3][3:0]};

  // Decode of the closed frame; mode words take precedence over the period form.
  always_comb begin
    res_command = CMD_UNKNOWN;
    res_period  = '0;
    priority if (count_r == MODE_CNT && word == WORD_NORM) begin
      res_command = CMD_NORMAL;
    end else if (count_r == MODE_CNT && word == WORD_HUMD) begin
      res_command = CMD_HUMID;
    end else if (count_r == MODE_CNT && word == WORD_TEMP) begin
      res_command = CMD_TEMP;
    end else if (count_r != '0 && eff[0] == BYTE_T && eff[1] == BYTE_USCORE) begin
      res_command = CMD_PERIOD;
      if (dig2 && dig3) begin
        res_period = (d2 << 3) + (d2 << 1) + d3;
      end else if (dig2) begin
        res_period = d2;
      end
    end
  end

  // Result register with a skid entry so that a stalled result does not block input.
  assign out_held = out_valid_r & out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_held) begin
      if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_held) begin
      if (res_valid) begin
        skid_command_r <= res_command;
        skid_period_r  <= res_period;
      end
    end else if (skid_valid_r) begin
      out_command_r <= skid_command_r;
      out_period_r  <= skid_period_r;
    end else if (res_valid) begin
      out_command_r <= res_command;
      out_period_r  <= res_period;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = out_command_r;
  assign out_period_value = out_period_r;

endmodule

### sv/ucfd_checker.sv
`include "uart_command_frame_decoder_core_macros.svh"

module ucfd_checker
  import ucfd_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input byte_t   in_rx_byte,
  input logic    out_valid,
  input logic    out_stall,
  input cmd_t    out_command,
  input period_t out_period_value
);

  // A stalled result stays on the port unchanged.
  `UCFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_command) && $stable(out_period_value), "result changed while stalled")

  // Only the five defined commands are ever reported.
  `UCFD_ASSERT_SAME(a_cmd_range, out_valid, out_command <= CMD_UNKNOWN, "command code out of range")

  // A period value is carried only by a set-period result.
  `UCFD_ASSERT_SAME(a_period_zero, out_valid && out_command != CMD_PERIOD, out_period_value == '0, "period value on a non-period result")

  // Two decimal digits cannot exceed ninety-nine.
  `UCFD_ASSERT_SAME(a_period_max, out_valid, out_period_value <= PERIOD_MAX, "period value above two digits")

endmodule

bind uart_command_frame_decoder_core ucfd_checker u_ucfd_checker (.*);

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucfd_pkg::*;

  localparam int FRAME_LEN    = 6;
  localparam int SLOTS        = FRAME_LEN - 1;
  localparam int MODE_FILL    = 5;
  localparam int HOLD_CYCLES  = 60;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 10;

  // One decoded frame as it leaves the result channel.
  typedef struct packed {
    cmd_t    command;
    period_t period_value;
  } frame_result_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  byte_t   in_rx_byte;
  logic    out_valid;
  logic    out_stall;
  cmd_t    out_command;
  period_t out_period_value;

  // Shadow copy of the decoder state.
  phase_t  frame_phase;
  int      frame_fill;
  byte_t   frame_buf [SLOTS];

  frame_result_t pending_results[$];
  int      error_count = 0;
  int      bytes_used = 0;
  int      idle_cycles = 0;
  bit      sender_burst = 1'b0;
  bit      receiver_burst = 1'b0;
  bit      long_hold = 1'b0;

  uart_command_frame_decoder_core #(
    .FRAME_LEN(FRAME_LEN)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_period_value(out_period_value)
  );

  always #1 clk = ~clk;

  // Work out the result of the frame now held in the shadow buffer.
  function automatic frame_result_t decode_frame();
    frame_result_t r;
    logic [31:0]   word;
    int unsigned   value;
    bit            stop;
    r.command      = CMD_UNKNOWN;
    r.period_value = '0;
    value          = 0;
    stop           = 1'b0;
    word = {frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3]};
    // Mode words need exactly four bytes before the close.
    if (frame_fill == MODE_FILL) begin
      if (word == WORD_NORM) r.command = CMD_NORMAL;
      else if (word == WORD_HUMD) r.command = CMD_HUMID;
      else if (word == WORD_TEMP) r.command = CMD_TEMP;
    end
    if (r.command == CMD_UNKNOWN && frame_fill >= 2 &&
        frame_buf[0] == BYTE_T && frame_buf[1] == BYTE_USCORE) begin
      // Only the two bytes after the prefix may hold digits.
      for (int i = 2; i < 4 && i < frame_fill; i++) begin
        if (!stop) begin
          if (frame_buf[i] >= BYTE_ZERO && frame_buf[i] <= BYTE_NINE)
            value = value * 10 + (frame_buf[i] - BYTE_ZERO);
          else
            stop = 1'b1;
        end
      end
      r.command      = CMD_PERIOD;
      r.period_value = period_t'(value);
    end
    return r;
  endfunction

  // Advance the shadow state by one accepted byte request.
  function automatic void track_byte(byte_t b);
    if (b == BYTE_START) begin
      bytes_used++;
      frame_phase = PHASE_COLLECT;
      frame_fill  = 0;
      return;
    end
    if (frame_phase != PHASE_COLLECT)
      return;
    bytes_used++;
    frame_buf[frame_fill] = b;
    frame_fill++;
    if (b == BYTE_END) begin
      pending_results.push_back(decode_frame());
      frame_phase = PHASE_IDLE;
      frame_fill  = 0;
    end else if (frame_fill >= SLOTS) begin
      frame_phase = PHASE_DISCARD;
      frame_fill  = 0;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Offer one byte request after a random gap and wait until it is taken.
  task automatic send_byte(byte_t b);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(byte_t'(s[i]));
  endtask

  // Any byte that neither opens nor closes a frame.
  function automatic byte_t pick_plain_byte();
    byte_t b;
    do b = byte_t'($urandom_range(0, 255));
    while (b == BYTE_START || b == BYTE_END);
    return b;
  endfunction

  // One random frame, mostly well formed, sometimes broken or pure noise.
  task automatic send_random_frame();
    byte_t       body[$];
    logic [31:0] word;
    int          kind;
    int          n;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        case ($urandom_range(0, 2))
          0: word = WORD_NORM;
          1: word = WORD_HUMD;
          default: word = WORD_TEMP;
        endcase
        body = {BYTE_START, word[31:24], word[23:16], word[15:8], word[7:0], BYTE_END};
        if ($urandom_range(0, 3) == 0)
          body[$urandom_range(1, 4)] = pick_plain_byte();
      end
      3, 4, 5: begin
        body = {BYTE_START, BYTE_T, BYTE_USCORE};
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0)
            body.push_back(pick_plain_byte());
          else
            body.push_back(byte_t'(BYTE_ZERO + $urandom_range(0, 9)));
        end
        body.push_back(BYTE_END);
      end
      6: begin
        body = {BYTE_START};
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          body.push_back(pick_plain_byte());
        body.push_back(BYTE_END);
      end
      7: begin
        // Overlong frame, sometimes followed by a stray close.
        body = {BYTE_START};
        n = $urandom_range(5, 8);
        for (int i = 0; i < n; i++)
          body.push_back(pick_plain_byte());
        if ($urandom_range(0, 1) == 1)
          body.push_back(BYTE_END);
      end
      8: begin
        // Partial frame cut short by a fresh start.
        body = {BYTE_START};
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          body.push_back(pick_plain_byte());
        body.push_back(BYTE_START);
        body.push_back(pick_plain_byte());
        body.push_back(BYTE_END);
      end
      default: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          body.push_back(byte_t'($urandom_range(0, 255)));
      end
    endcase
    foreach (body[i])
      send_byte(body[i]);
  endtask

  // Bytes outside any frame, including the extremes and a lone close.
  task automatic test_outside_bytes();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(BYTE_END);
  endtask

  // A start in the middle of a frame drops the partial one.
  task automatic test_restart();
    send_text("&hu&temp*");
  endtask

  task automatic test_period_extreme();
    send_text("&T_99*");
  endtask

  // Empty frame, then an overlong one whose close must be ignored.
  task automatic test_empty_and_overlong();
    send_text("&*");
    send_text("&abcde");
    send_byte(BYTE_END);
  endtask

  task automatic test_random_frames(int count);
    int target;
    target = bytes_used + count;
    while (bytes_used < target)
      send_random_frame();
  endtask

  // Both sides at full rate.
  task automatic test_back_to_back(int count);
    sender_burst   = 1'b1;
    receiver_burst = 1'b1;
    test_random_frames(count);
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  // The receiver holds off while short frames keep coming, filling the block.
  task automatic test_receiver_hold_off();
    long_hold    = 1'b1;
    sender_burst = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0)
        send_text("&*");
      else
        send_text("&T_7*");
    end
    sender_burst = 1'b0;
  endtask

  // Receiver: random stalls per result, with an occasional long hold-off.
  initial begin : receiver
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_cycles = receiver_burst ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1 && !long_hold);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result command=%0d period=%0d",
                                  out_command, out_period_value));
      end else begin
        want = pending_results.pop_front();
        if (out_command !== want.command)
          report_mismatch($sformatf("command got %0d want %0d",
                                    out_command, want.command));
        if (out_period_value !== want.period_value)
          report_mismatch($sformatf("period_value got %0d want %0d",
                                    out_period_value, want.period_value));
      end
    end
  end

  // Watchdog on cycles in which no request moves on either side.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rx_byte  <= '0;
    frame_phase  = PHASE_IDLE;
    frame_fill   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_outside_bytes();
    test_restart();
    test_period_extreme();
    test_empty_and_overlong();
    test_random_frames(300);
    test_back_to_back(100);
    test_receiver_hold_off();
    test_random_frames(100);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/ucfd_pkg.sv
sv/uart_command_frame_decoder_core.sv
sv/ucfd_checker.sv
test/tb.sv
